FILE: hdl/cipc_pkg.sv
// shared types, constants and coefficient tables for the colour index converter
`default_nettype none
package cipc_pkg;

    localparam int FRAC_BITS = 24;
    localparam int POLY_TERMS_DEF = 13;
    localparam int MAX_ITER_DEF = 100;

    localparam int VAL_W = 32;
    localparam int ACC_W = 42;
    localparam int MB_W = 34;
    localparam int LIM_W = 34;
    localparam int PROD_W = 76;
    localparam int MR_W = PROD_W - FRAC_BITS;
    localparam int SUM_W = MR_W + 1;
    localparam int DIV_W = 33;
    localparam int Q_W = FRAC_BITS + 1;

    localparam longint NANO = 64'sd1000000000;
    localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_FX = ONE_FX / 2;
    localparam longint ACC_LIMIT = 64'sd1 <<< 40;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    localparam logic [2:0] MODE_VI_BV = 3'd0;
    localparam logic [2:0] MODE_BV_VI = 3'd1;
    localparam logic [2:0] MODE_VI_VR = 3'd2;
    localparam logic [2:0] MODE_VR_VI = 3'd3;
    localparam logic [2:0] MODE_VR_BV = 3'd4;
    localparam logic [2:0] MODE_BV_VR = 3'd5;

    localparam longint COEF_NANO [4][16] = '{
        '{-64'sd68650720, 64'sd883799700, -64'sd388977400, -64'sd4998126,
          64'sd386754400, -64'sd542233100, -64'sd89264760, 64'sd519479700,
          -64'sd204468100, -64'sd100902500, 64'sd95432560, -64'sd25675290,
          64'sd2393742, 64'sd0, 64'sd0, 64'sd0},
        '{-64'sd470837300, 64'sd592072800, -64'sd10952940, -64'sd228111800,
          -64'sd93728920, 64'sd193139300, 64'sd50772530, -64'sd99272840,
          64'sd8560631, 64'sd19227020, -64'sd7201880, 64'sd774302,
          64'sd0, 64'sd0, 64'sd0, 64'sd0},
        '{64'sd486042900, 64'sd690400800, -64'sd1229411000, 64'sd2990030000,
          64'sd7104513000, -64'sd16377990000, -64'sd29771230000, 64'sd43907510000,
          64'sd61458100000, -64'sd52653580000, -64'sd61359210000, 64'sd22978350000,
          64'sd23850130000, 64'sd0, 64'sd0, 64'sd0},
        '{-64'sd414095100, 64'sd735716500, -64'sd52429790, -64'sd629330400,
          64'sd2332871000, 64'sd3812365000, -64'sd5082941000, -64'sd6520325000,
          64'sd4817797000, 64'sd5065505000, -64'sd1706011000, -64'sd1568243000,
          64'sd0, 64'sd0, 64'sd0, 64'sd0}
    };

    localparam longint LIM_NANO [4][2] = '{
        '{-64'sd230000000, 64'sd3700000000},
        '{-64'sd300000000, 64'sd4000000000},
        '{-64'sd100000000, 64'sd1750000000},
        '{-64'sd230000000, 64'sd1950000000}
    };

    function automatic longint to_fixed(input longint nano);
        longint mag;
        longint q;
        longint r;
        longint f;
        mag = (nano < 0) ? -nano : nano;
        q = mag / NANO;
        r = mag % NANO;
        f = (q <<< FRAC_BITS) + ((r <<< FRAC_BITS) + NANO / 2) / NANO;
        return (nano < 0) ? -f : f;
    endfunction

    typedef logic [3:0][15:0][ACC_W-1:0] coef_tab_t;
    typedef logic [3:0][1:0][LIM_W-1:0] lim_tab_t;

    function automatic coef_tab_t build_coef();
        coef_tab_t res;
        for (int t = 0; t < 4; t++) begin
            for (int k = 0; k < 16; k++) begin
                res[t][k] = ACC_W'(to_fixed(COEF_NANO[t][k]));
            end
        end
        return res;
    endfunction

    function automatic lim_tab_t build_lim();
        lim_tab_t res;
        for (int t = 0; t < 4; t++) begin
            for (int j = 0; j < 2; j++) begin
                res[t][j] = LIM_W'(to_fixed(LIM_NANO[t][j]));
            end
        end
        return res;
    endfunction

    localparam coef_tab_t COEF_FX = build_coef();
    localparam lim_tab_t LIM_FX = build_lim();
    localparam longint THR_FX = to_fixed(64'sd1000);

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOCONV = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PT_RES = 2'd0,
        PT_CLO = 2'd1,
        PT_CHI = 2'd2,
        PT_CR  = 2'd3
    } poly_tag_t;

    typedef enum logic [1:0] {
        MS_POLY = 2'd0,
        MS_C1   = 2'd1,
        MS_C2   = 2'd2,
        MS_STEP = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      inv_init;
        logic      poly_load;
        logic      poly_acc;
        logic      poly_end;
        poly_tag_t poly_tag;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      iter_load;
        logic      div_start;
        logic      div_end;
        logic      c1_end;
        logic      c2_end;
        logic      step_end;
        logic      update;
        logic      set_err;
        status_t   err_code;
        logic      res_from_r;
        logic      out_load;
    } cipc_cmd_t;

    typedef struct packed {
        logic mode_bad;
        logic mode_inv;
        logic fwd_out;
        logic inv_out;
        logic mul_done;
        logic div_done;
        logic k_last;
        logic iter_zero;
        logic wide;
    } cipc_stat_t;

endpackage
`default_nettype wire

FILE: hdl/cipc_mul.sv
// shared multiplier: floor(a*b / 2^frac) from two partial products, low half then high half
`default_nettype none
module cipc_mul (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [cipc_pkg::ACC_W-1:0] a,
    input  wire logic signed [cipc_pkg::MB_W-1:0]  b,
    output logic                                   done,
    output logic signed [cipc_pkg::MR_W-1:0]       y
);

    localparam int HALF_W = cipc_pkg::ACC_W / 2;
    localparam int PP_W = HALF_W + 1 + cipc_pkg::MB_W;
    localparam int PW = cipc_pkg::PROD_W;

    logic signed [cipc_pkg::ACC_W-1:0] a_reg;
    logic signed [cipc_pkg::MB_W-1:0]  b_reg;
    logic [1:0]                        ph_reg;
    logic signed [PP_W-1:0]            plo_reg;
    logic signed [PP_W-1:0]            phi_reg;
    logic signed [cipc_pkg::MR_W-1:0]  y_reg;
    logic                              done_reg;

    logic signed [HALF_W:0] op_a;
    logic signed [PP_W-1:0] prod;
    logic [PW-1:0]          full;

    always_comb begin
        if (ph_reg == 2'd2) begin
            op_a = {a_reg[cipc_pkg::ACC_W-1], a_reg[cipc_pkg::ACC_W-1:HALF_W]};
        end else begin
            op_a = {1'b0, a_reg[HALF_W-1:0]};
        end
    end

    assign prod = op_a * b_reg;
    assign full = ({{(PW-PP_W){phi_reg[PP_W-1]}}, phi_reg} << HALF_W)
                + {{(PW-PP_W){plo_reg[PP_W-1]}}, plo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (ph_reg)
                2'd0: begin
                    if (start) begin
                        ph_reg <= 2'd1;
                    end
                end
                2'd1: ph_reg <= 2'd2;
                2'd2: ph_reg <= 2'd3;
                default: begin
                    ph_reg <= 2'd0;
                    done_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        if (ph_reg == 2'd1) begin
            plo_reg <= prod;
        end
        if (ph_reg == 2'd2) begin
            phi_reg <= prod;
        end
        if (ph_reg == 2'd3) begin
            y_reg <= $signed(full[PW-1:cipc_pkg::FRAC_BITS]);
        end
    end

    assign done = done_reg;
    assign y = y_reg;

endmodule
`default_nettype wire

FILE: hdl/cipc_div.sv
// restoring divider: floor(num * 2^frac / den), one quotient bit per cycle
`default_nettype none
module cipc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cipc_pkg::DIV_W-1:0]    num,
    input  wire logic [cipc_pkg::DIV_W-1:0]    den,
    output logic                               done,
    output logic [cipc_pkg::Q_W-1:0]           q
);

    localparam int CNT_W = $clog2(cipc_pkg::Q_W + 1);
    localparam int DW = cipc_pkg::DIV_W;

    logic [DW:0]                  rem_reg;
    logic [DW-1:0]                den_reg;
    logic [cipc_pkg::Q_W-1:0]     q_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         done_reg;

    logic          ge;
    logic [DW:0]   diff;

    assign ge = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(cipc_pkg::Q_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg <= '0;
        end else if (cnt_reg != '0) begin
            q_reg <= {q_reg[cipc_pkg::Q_W-2:0], ge};
            rem_reg <= {diff[DW-1:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule
`default_nettype wire

FILE: hdl/cipc_dp.sv
// datapath: mode register, bracket registers, horner accumulator, shared units, output register
`default_nettype none
module cipc_dp #(
    parameter int POLY_TERMS = cipc_pkg::POLY_TERMS_DEF,
    parameter int SEARCH_LIMIT = cipc_pkg::MAX_ITER_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_wr_data,
    input  wire logic signed [cipc_pkg::VAL_W-1:0] s_color_in,
    input  wire cipc_pkg::cipc_cmd_t               cmd,
    output cipc_pkg::cipc_stat_t                   stat,
    output logic signed [cipc_pkg::VAL_W-1:0]      m_color_out,
    output logic [1:0]                             m_status
);

    localparam int K_W = $clog2(POLY_TERMS);
    localparam int I_W = $clog2(SEARCH_LIMIT + 1);
    localparam int LW = cipc_pkg::LIM_W;
    localparam int AW = cipc_pkg::ACC_W;
    localparam int VW = cipc_pkg::VAL_W;
    localparam int SW = cipc_pkg::SUM_W;
    localparam int DW = cipc_pkg::DIV_W;

    logic [2:0]              mode_reg;
    logic signed [VW-1:0]    y_reg;
    logic signed [LW-1:0]    lo_reg;
    logic signed [LW-1:0]    hi_reg;
    logic signed [VW-1:0]    clo_reg;
    logic signed [VW-1:0]    chi_reg;
    logic signed [VW-1:0]    cr_reg;
    logic signed [LW-1:0]    r_reg;
    logic signed [LW-1:0]    u_reg;
    logic signed [AW-1:0]    m_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [LW-1:0]    t_reg;
    logic [K_W-1:0]          k_reg;
    logic [I_W-1:0]          iter_reg;
    logic signed [VW-1:0]    res_reg;
    cipc_pkg::status_t       status_reg;
    logic signed [VW-1:0]    out_data_reg;
    logic [1:0]              out_status_reg;

    logic [1:0]                          tab;
    logic                                mode_bad;
    logic                                mode_inv;
    logic signed [LW-1:0]                lim_lo;
    logic signed [LW-1:0]                lim_hi;
    logic signed [LW-1:0]                y_ext;
    logic signed [AW-1:0]                coef_top;
    logic signed [AW-1:0]                coef_k;
    logic signed [LW-1:0]                poly_x;
    logic signed [AW-1:0]                mul_a;
    logic signed [cipc_pkg::MB_W-1:0]    mul_b;
    logic                                mul_done;
    logic signed [cipc_pkg::MR_W-1:0]    mul_y;
    logic signed [SW-1:0]                acc_sum;
    logic signed [AW-1:0]                acc_clamped;
    logic signed [AW:0]                  pv_sum;
    logic signed [VW-1:0]                pv;
    logic signed [DW-1:0]                num;
    logic signed [DW-1:0]                den;
    logic [DW-1:0]                       div_num;
    logic [DW-1:0]                       div_den;
    logic                                div_done;
    logic [cipc_pkg::Q_W-1:0]            div_q;
    logic signed [SW-1:0]                c2_sum;
    logic signed [SW-1:0]                step_sum;
    logic signed [LW-1:0]                hl_diff;

    always_comb begin
        tab = 2'd0;
        mode_bad = 1'b0;
        mode_inv = 1'b0;
        case (mode_reg)
            cipc_pkg::MODE_VI_BV: tab = 2'd0;
            cipc_pkg::MODE_BV_VI: begin
                tab = 2'd0;
                mode_inv = 1'b1;
            end
            cipc_pkg::MODE_VI_VR: tab = 2'd1;
            cipc_pkg::MODE_VR_VI: begin
                tab = 2'd1;
                mode_inv = 1'b1;
            end
            cipc_pkg::MODE_VR_BV: tab = 2'd2;
            cipc_pkg::MODE_BV_VR: tab = 2'd3;
            default: mode_bad = 1'b1;
        endcase
    end

    assign lim_lo = $signed(cipc_pkg::LIM_FX[tab][0]);
    assign lim_hi = $signed(cipc_pkg::LIM_FX[tab][1]);
    assign y_ext = LW'(y_reg);
    assign coef_top = $signed(cipc_pkg::COEF_FX[tab][4'(POLY_TERMS - 1)]);
    assign coef_k = $signed(cipc_pkg::COEF_FX[tab][4'(k_reg - 1'b1)]);

    always_comb begin
        case (cmd.poly_tag)
            cipc_pkg::PT_RES: poly_x = y_ext;
            cipc_pkg::PT_CLO: poly_x = lo_reg;
            cipc_pkg::PT_CHI: poly_x = hi_reg;
            cipc_pkg::PT_CR:  poly_x = r_reg;
            default:          poly_x = y_ext;
        endcase
    end

    assign hl_diff = hi_reg - lo_reg;

    always_comb begin
        case (cmd.mul_sel)
            cipc_pkg::MS_POLY: begin
                mul_a = acc_reg;
                mul_b = t_reg;
            end
            cipc_pkg::MS_C1: begin
                mul_a = AW'(u_reg);
                mul_b = u_reg - LW'(cipc_pkg::HALF_FX);
            end
            cipc_pkg::MS_C2: begin
                mul_a = m_reg;
                mul_b = u_reg - LW'(cipc_pkg::ONE_FX);
            end
            cipc_pkg::MS_STEP: begin
                mul_a = AW'(hl_diff);
                mul_b = u_reg;
            end
            default: begin
                mul_a = acc_reg;
                mul_b = t_reg;
            end
        endcase
    end

    cipc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .y       (mul_y)
    );

    assign acc_sum = SW'(mul_y) + SW'(coef_k);

    always_comb begin
        if (acc_sum > cipc_pkg::ACC_LIMIT) begin
            acc_clamped = AW'(cipc_pkg::ACC_LIMIT);
        end else if (acc_sum < -cipc_pkg::ACC_LIMIT) begin
            acc_clamped = AW'(-cipc_pkg::ACC_LIMIT);
        end else begin
            acc_clamped = AW'(acc_sum);
        end
    end

    assign pv_sum = (AW + 1)'(acc_reg) + (AW + 1)'(cipc_pkg::ONE_FX);

    always_comb begin
        if (pv_sum > cipc_pkg::VAL_MAX) begin
            pv = VW'(cipc_pkg::VAL_MAX);
        end else if (pv_sum < cipc_pkg::VAL_MIN) begin
            pv = VW'(cipc_pkg::VAL_MIN);
        end else begin
            pv = VW'(pv_sum);
        end
    end

    assign num = DW'(y_reg) - DW'(clo_reg);
    assign den = DW'(chi_reg) - DW'(clo_reg);
    assign div_num = (den > 0 && num > 0) ? unsigned'(num) : '0;
    assign div_den = (den > 0) ? unsigned'(den) : DW'(1);

    cipc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .q       (div_q)
    );

    assign c2_sum = SW'(u_reg) + SW'(mul_y);
    assign step_sum = SW'(lo_reg) + SW'(mul_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cipc_pkg::MODE_VI_BV;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            y_reg <= s_color_in;
        end
        if (cmd.inv_init) begin
            lo_reg <= lim_lo;
            hi_reg <= lim_hi;
        end
        if (cmd.poly_load) begin
            acc_reg <= coef_top;
            k_reg <= K_W'(POLY_TERMS - 1);
            t_reg <= poly_x - LW'(cipc_pkg::ONE_FX);
        end
        if (cmd.poly_acc) begin
            acc_reg <= acc_clamped;
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.poly_end) begin
            case (cmd.poly_tag)
                cipc_pkg::PT_RES: begin
                    res_reg <= pv;
                    status_reg <= cipc_pkg::ST_OK;
                end
                cipc_pkg::PT_CLO: clo_reg <= pv;
                cipc_pkg::PT_CHI: chi_reg <= pv;
                cipc_pkg::PT_CR:  cr_reg <= pv;
                default:          cr_reg <= pv;
            endcase
        end
        if (cmd.iter_load) begin
            iter_reg <= I_W'(SEARCH_LIMIT);
        end
        if (cmd.div_end) begin
            if (div_q > cipc_pkg::Q_W'(cipc_pkg::ONE_FX)) begin
                u_reg <= LW'(cipc_pkg::ONE_FX);
            end else begin
                u_reg <= LW'(div_q);
            end
        end
        if (cmd.c1_end) begin
            m_reg <= AW'(mul_y);
        end
        if (cmd.c2_end) begin
            if (c2_sum < 0) begin
                u_reg <= '0;
            end else if (c2_sum > cipc_pkg::ONE_FX) begin
                u_reg <= LW'(cipc_pkg::ONE_FX);
            end else begin
                u_reg <= LW'(c2_sum);
            end
        end
        if (cmd.step_end) begin
            if (step_sum < SW'(lo_reg)) begin
                r_reg <= lo_reg;
            end else if (step_sum > SW'(hi_reg)) begin
                r_reg <= hi_reg;
            end else begin
                r_reg <= LW'(step_sum);
            end
        end
        if (cmd.update) begin
            if (cr_reg < y_reg) begin
                lo_reg <= r_reg;
                clo_reg <= cr_reg;
            end else begin
                hi_reg <= r_reg;
                chi_reg <= cr_reg;
            end
            iter_reg <= iter_reg - 1'b1;
        end
        if (cmd.set_err) begin
            res_reg <= '0;
            status_reg <= cmd.err_code;
        end
        if (cmd.res_from_r) begin
            res_reg <= VW'(r_reg);
            status_reg <= cipc_pkg::ST_OK;
        end
        if (cmd.out_load) begin
            out_data_reg <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    always_comb begin
        stat.mode_bad = mode_bad;
        stat.mode_inv = mode_inv;
        stat.fwd_out = (y_ext < lim_lo) || (y_ext > lim_hi);
        stat.inv_out = (y_reg < clo_reg) || (y_reg > chi_reg);
        stat.mul_done = mul_done;
        stat.div_done = div_done;
        stat.k_last = (k_reg == K_W'(1));
        stat.iter_zero = (iter_reg == '0);
        stat.wide = hl_diff > cipc_pkg::THR_FX;
    end

    assign m_color_out = out_data_reg;
    assign m_status = out_status_reg;

endmodule
`default_nettype wire

FILE: hdl/cipc_ctrl.sv
// controller: sequences decode, horner passes, root search and result hand-off
`default_nettype none
module cipc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire cipc_pkg::cipc_stat_t stat,
    output cipc_pkg::cipc_cmd_t       cmd
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_DECODE = 19'b0000000000000000010,
        S_PLOAD  = 19'b0000000000000000100,
        S_PMUL   = 19'b0000000000000001000,
        S_PWAIT  = 19'b0000000000000010000,
        S_PACC   = 19'b0000000000000100000,
        S_PEND   = 19'b0000000000001000000,
        S_RANGE  = 19'b0000000000010000000,
        S_DIV    = 19'b0000000000100000000,
        S_DIVW   = 19'b0000000001000000000,
        S_C1     = 19'b0000000010000000000,
        S_C1W    = 19'b0000000100000000000,
        S_C2     = 19'b0000001000000000000,
        S_C2W    = 19'b0000010000000000000,
        S_STEP   = 19'b0000100000000000000,
        S_STEPW  = 19'b0001000000000000000,
        S_UPDATE = 19'b0010000000000000000,
        S_TEST   = 19'b0100000000000000000,
        S_FINISH = 19'b1000000000000000000
    } state_t;

    state_t                state_reg, state_next;
    cipc_pkg::poly_tag_t   tag_reg, tag_next;
    logic                  m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        tag_next = tag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        cmd.poly_tag = tag_reg;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.mode_bad) begin
                    cmd.set_err = 1'b1;
                    cmd.err_code = cipc_pkg::ST_RANGE;
                    state_next = S_FINISH;
                end else if (stat.mode_inv) begin
                    cmd.inv_init = 1'b1;
                    tag_next = cipc_pkg::PT_CLO;
                    state_next = S_PLOAD;
                end else if (stat.fwd_out) begin
                    cmd.set_err = 1'b1;
                    cmd.err_code = cipc_pkg::ST_RANGE;
                    state_next = S_FINISH;
                end else begin
                    tag_next = cipc_pkg::PT_RES;
                    state_next = S_PLOAD;
                end
            end
            S_PLOAD: begin
                cmd.poly_load = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = cipc_pkg::MS_POLY;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                if (stat.mul_done) begin
                    state_next = S_PACC;
                end
            end
            S_PACC: begin
                cmd.poly_acc = 1'b1;
                state_next = stat.k_last ? S_PEND : S_PMUL;
            end
            S_PEND: begin
                cmd.poly_end = 1'b1;
                case (tag_reg)
                    cipc_pkg::PT_RES: state_next = S_FINISH;
                    cipc_pkg::PT_CLO: begin
                        tag_next = cipc_pkg::PT_CHI;
                        state_next = S_PLOAD;
                    end
                    cipc_pkg::PT_CHI: state_next = S_RANGE;
                    cipc_pkg::PT_CR:  state_next = S_UPDATE;
                    default:          state_next = S_FINISH;
                endcase
            end
            S_RANGE: begin
                if (stat.inv_out) begin
                    cmd.set_err = 1'b1;
                    cmd.err_code = cipc_pkg::ST_RANGE;
                    state_next = S_FINISH;
                end else begin
                    cmd.iter_load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.div_end = 1'b1;
                    state_next = S_C1;
                end
            end
            S_C1: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = cipc_pkg::MS_C1;
                state_next = S_C1W;
            end
            S_C1W: begin
                cmd.mul_sel = cipc_pkg::MS_C1;
                if (stat.mul_done) begin
                    cmd.c1_end = 1'b1;
                    state_next = S_C2;
                end
            end
            S_C2: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = cipc_pkg::MS_C2;
                state_next = S_C2W;
            end
            S_C2W: begin
                if (stat.mul_done) begin
                    cmd.c2_end = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = cipc_pkg::MS_STEP;
                state_next = S_STEPW;
            end
            S_STEPW: begin
                if (stat.mul_done) begin
                    cmd.step_end = 1'b1;
                    tag_next = cipc_pkg::PT_CR;
                    state_next = S_PLOAD;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (stat.wide && !stat.iter_zero) begin
                    state_next = S_DIV;
                end else if (stat.iter_zero) begin
                    cmd.set_err = 1'b1;
                    cmd.err_code = cipc_pkg::ST_NOCONV;
                    state_next = S_FINISH;
                end else begin
                    cmd.res_from_r = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tag_reg <= cipc_pkg::PT_RES;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tag_reg <= tag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

FILE: hdl/color_index_polynomial_converter_core.sv
// top level of the colour index converter: controller plus datapath
//
// input channel s_valid/s_ready/s_color_in carries one signed Q8.24 index per
// transaction; output channel m_valid/m_ready carries m_color_out and m_status
// (0 ok, 1 out of range or unused mode, 2 no convergence; m_color_out 0 on error)
// cfg_wr_en/cfg_wr_data write the 3-bit conversion mode; the user writes it only
// while idle, as the block does not enforce it; one item is worked at a time;
// s_ready is high only in the idle state; forward modes: one horner pass of
// POLY_TERMS-1 multiplies on the shared multiplier
// inverse modes: two polynomial passes, then per search iteration one
// serial division, three multiplies and one polynomial pass, up to
// SEARCH_LIMIT iterations
// range errors skip the horner pass (forward) or the search (inverse)
// the result sits in an output register; a stalled receiver holds the next
// finished result in res_reg, the controller waiting until the register frees
// reset (aresetn low, synchronous) clears the mode to 0 and drops m_valid
`default_nettype none
module color_index_polynomial_converter_core #(
    parameter int POLY_TERMS = cipc_pkg::POLY_TERMS_DEF,
    parameter int SEARCH_LIMIT = cipc_pkg::MAX_ITER_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [cipc_pkg::VAL_W-1:0] s_color_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [cipc_pkg::VAL_W-1:0]      m_color_out,
    output logic [1:0]                             m_status
);

    cipc_pkg::cipc_cmd_t  cmd;
    cipc_pkg::cipc_stat_t stat;

    cipc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cipc_dp #(
        .POLY_TERMS   (POLY_TERMS),
        .SEARCH_LIMIT (SEARCH_LIMIT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_color_in  (s_color_in),
        .cmd         (cmd),
        .stat        (stat),
        .m_color_out (m_color_out),
        .m_status    (m_status)
    );

endmodule
`default_nettype wire

FILE: sim/color_index_polynomial_converter_core_test.sv
// testbench for the colour index converter: directed table, then random transactions
`default_nettype none
module color_index_polynomial_converter_core_test;

    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam longint BILLION = 64'sd1000000000;
    localparam int TERMS = 13;
    localparam int ITER_LIMIT = 100;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // table coefficients and limits in units of 1e-9
    localparam longint COEF_E9 [4][TERMS] = '{
        '{-64'sd68650720, 64'sd883799700, -64'sd388977400, -64'sd4998126,
          64'sd386754400, -64'sd542233100, -64'sd89264760, 64'sd519479700,
          -64'sd204468100, -64'sd100902500, 64'sd95432560, -64'sd25675290,
          64'sd2393742},
        '{-64'sd470837300, 64'sd592072800, -64'sd10952940, -64'sd228111800,
          -64'sd93728920, 64'sd193139300, 64'sd50772530, -64'sd99272840,
          64'sd8560631, 64'sd19227020, -64'sd7201880, 64'sd774302, 64'sd0},
        '{64'sd486042900, 64'sd690400800, -64'sd1229411000, 64'sd2990030000,
          64'sd7104513000, -64'sd16377990000, -64'sd29771230000,
          64'sd43907510000, 64'sd61458100000, -64'sd52653580000,
          -64'sd61359210000, 64'sd22978350000, 64'sd23850130000},
        '{-64'sd414095100, 64'sd735716500, -64'sd52429790, -64'sd629330400,
          64'sd2332871000, 64'sd3812365000, -64'sd5082941000, -64'sd6520325000,
          64'sd4817797000, 64'sd5065505000, -64'sd1706011000, -64'sd1568243000,
          64'sd0}
    };
    localparam longint LIMIT_E9 [4][2] = '{
        '{-64'sd230000000, 64'sd3700000000},
        '{-64'sd300000000, 64'sd4000000000},
        '{-64'sd100000000, 64'sd1750000000},
        '{-64'sd230000000, 64'sd1950000000}
    };

    typedef struct {
        logic signed [31:0] color;
        logic [1:0]         status;
    } conversion_t;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] color_in;
        bit                 typed;
        logic signed [31:0] color_out;
        logic [1:0]         status;
    } directed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_wr_data = 3'd0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_color_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_color_out;
    logic [1:0]         m_status;

    conversion_t pending_conversions[$];
    logic [2:0]  current_mode = cipc_pkg::MODE_VI_BV;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;

    color_index_polynomial_converter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_color_in(s_color_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_color_out(m_color_out), .m_status(m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint fixed_of_e9(longint e9);
        longint mag, whole, part, f;
        mag = (e9 < 0) ? -e9 : e9;
        whole = mag / BILLION;
        part = mag % BILLION;
        f = (whole <<< cipc_pkg::FRAC_BITS)
            + ((part <<< cipc_pkg::FRAC_BITS) + BILLION / 2) / BILLION;
        return (e9 < 0) ? -f : f;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint ah, al;
        ah = a >>> cipc_pkg::FRAC_BITS;
        al = a - (ah <<< cipc_pkg::FRAC_BITS);
        return ah * b + ((al * b) >>> cipc_pkg::FRAC_BITS);
    endfunction

    function automatic longint table_poly(int tab, longint x);
        longint t, acc;
        t = x - cipc_pkg::ONE_FX;
        acc = fixed_of_e9(COEF_E9[tab][TERMS-1]);
        for (int k = TERMS - 2; k >= 0; k--) begin
            acc = fx_mul(acc, t) + fixed_of_e9(COEF_E9[tab][k]);
            acc = clip(acc, -cipc_pkg::ACC_LIMIT, cipc_pkg::ACC_LIMIT);
        end
        return clip(acc + cipc_pkg::ONE_FX, S32_MIN, S32_MAX);
    endfunction

    function automatic logic [1:0] root_search(int tab, longint y, output longint root);
        longint lo, hi, clo, chi, num, den, u, cr, r;
        int iter;
        lo = fixed_of_e9(LIMIT_E9[tab][0]);
        hi = fixed_of_e9(LIMIT_E9[tab][1]);
        clo = table_poly(tab, lo);
        chi = table_poly(tab, hi);
        root = 0;
        r = 0;
        iter = ITER_LIMIT;
        if (y < clo || y > chi) return cipc_pkg::ST_RANGE;
        do begin
            num = y - clo;
            den = chi - clo;
            u = 0;
            if (den > 0 && num > 0) u = (num <<< cipc_pkg::FRAC_BITS) / den;
            u = clip(u, 0, cipc_pkg::ONE_FX);
            u = u + fx_mul(fx_mul(u, u - cipc_pkg::ONE_FX / 2), u - cipc_pkg::ONE_FX);
            u = clip(u, 0, cipc_pkg::ONE_FX);
            r = clip(lo + fx_mul(hi - lo, u), lo, hi);
            cr = table_poly(tab, r);
            if (cr < y) begin
                lo = r;
                clo = cr;
            end else begin
                hi = r;
                chi = cr;
            end
            iter--;
        end while (hi - lo > fixed_of_e9(64'sd1000) && iter != 0);
        if (iter == 0) return cipc_pkg::ST_NOCONV;
        root = r;
        return cipc_pkg::ST_OK;
    endfunction

    function automatic conversion_t convert_index(logic [2:0] mode, logic signed [31:0] xin);
        conversion_t c;
        longint x, res;
        int tab;
        bit inv;
        x = xin;
        res = 0;
        inv = (mode == cipc_pkg::MODE_BV_VI || mode == cipc_pkg::MODE_VR_VI);
        case (mode)
            cipc_pkg::MODE_VI_BV, cipc_pkg::MODE_BV_VI: tab = 0;
            cipc_pkg::MODE_VI_VR, cipc_pkg::MODE_VR_VI: tab = 1;
            cipc_pkg::MODE_VR_BV: tab = 2;
            cipc_pkg::MODE_BV_VR: tab = 3;
            default: tab = -1;
        endcase
        if (tab < 0) begin
            c.status = cipc_pkg::ST_RANGE;
        end else if (inv) begin
            c.status = root_search(tab, x, res);
        end else if (x < fixed_of_e9(LIMIT_E9[tab][0]) || x > fixed_of_e9(LIMIT_E9[tab][1])) begin
            c.status = cipc_pkg::ST_RANGE;
        end else begin
            res = table_poly(tab, x);
            c.status = cipc_pkg::ST_OK;
        end
        c.color = (c.status == cipc_pkg::ST_OK) ? res[31:0] : 32'sd0;
        return c;
    endfunction

    task automatic drain_and_set_mode(logic [2:0] mode);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_conversions.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        current_mode = mode;
    endtask

    task automatic send_index(logic signed [31:0] x, bit typed, conversion_t typed_result);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_color_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_conversions.push_back(typed ? typed_result : convert_index(current_mode, x));
    endtask

    function automatic logic signed [31:0] pick_index(logic [2:0] mode);
        int tab;
        longint lo, hi;
        if ($urandom_range(99) < 25 || mode > cipc_pkg::MODE_BV_VR) return $urandom;
        if (mode == cipc_pkg::MODE_BV_VI || mode == cipc_pkg::MODE_VR_VI)
            return 32'(-64'sd33554432 + longint'($urandom_range(32'd167772160)));
        tab = (mode == cipc_pkg::MODE_VI_BV) ? 0 : (mode == cipc_pkg::MODE_VI_VR) ? 1 :
              (mode == cipc_pkg::MODE_VR_BV) ? 2 : 3;
        lo = fixed_of_e9(LIMIT_E9[tab][0]) - 1024;
        hi = fixed_of_e9(LIMIT_E9[tab][1]) + 1024;
        return 32'(lo + longint'($urandom_range(32'(hi - lo))));
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_conversions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: color_out %0d status %0d",
                             m_color_out, m_status);
            end else begin
                conversion_t want;
                want = pending_conversions.pop_front();
                if (m_color_out !== want.color || m_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d, got %0d/%0d",
                                 want.color, want.status, m_color_out, m_status);
                end
            end
        end
    end

    initial begin
        #50000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        directed_row_t rows[$];
        conversion_t typed_result;
        logic [2:0] mode;
        rows = '{
            '{cipc_pkg::MODE_VI_BV, 32'sd0, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VI_BV, 32'sd16777216, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VI_BV, -32'sd3858760, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VI_BV, 32'sd62075699, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VI_BV, -32'sd3858761, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VI_BV, 32'sd62075700, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VI_BV, 32'h80000000, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VI_BV, 32'h7fffffff, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_BV_VI, 32'sd8388608, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_BV_VI, 32'sd0, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_BV_VI, 32'h80000000, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_BV_VI, 32'h7fffffff, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VI_VR, 32'sd67108864, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VI_VR, 32'sd67108865, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VI_VR, -32'sd5033166, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VR_VI, 32'sd16777216, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VR_VI, 32'h80000000, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_VR_BV, 32'sd29360128, 0, 0, cipc_pkg::ST_OK},
            '{cipc_pkg::MODE_VR_BV, 32'sd29360129, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_BV_VR, -32'sd3858761, 1, 0, cipc_pkg::ST_RANGE},
            '{cipc_pkg::MODE_BV_VR, 32'sd32715571, 0, 0, cipc_pkg::ST_OK},
            '{MODE_UNUSED_6, 32'sd0, 1, 0, cipc_pkg::ST_RANGE},
            '{MODE_UNUSED_7, 32'h7fffffff, 1, 0, cipc_pkg::ST_RANGE}
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            if (rows[i].mode != current_mode) drain_and_set_mode(rows[i].mode);
            typed_result.color = rows[i].color_out;
            typed_result.status = rows[i].status;
            send_index(rows[i].color_in, rows[i].typed, typed_result);
        end
        // three idle regimes: mostly stalled receiver, mostly idle sender, none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
            for (int batch = 0; batch < 7; batch++) begin
                mode = (phase == 2 && batch == 0) ? cipc_pkg::MODE_BV_VR
                                                  : 3'($urandom_range(7));
                drain_and_set_mode(mode);
                repeat (20) send_index(pick_index(mode), 0, typed_result);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_conversions.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
